/* design/fnvlp_pkg.sv */
// Shared constants, codes and types of the FNV-1a linear-probe hash table.
package fnvlp_pkg;

    localparam int C_SLOT_COUNT = 8192;
    localparam int C_SLOT_W     = $clog2(C_SLOT_COUNT);
    localparam int C_COUNT_W    = $clog2(C_SLOT_COUNT + 1);
    localparam int C_KEY_W      = 32;
    localparam int C_HANDLE_W   = 32;
    localparam int C_IDX_W      = 13;

    localparam logic [31:0] C_FNV_PRIME = 32'h0100_0193;
    localparam logic [31:0] C_FNV_BASIS = 32'h811C_9DC5;

    typedef logic [C_SLOT_W-1:0] t_slot;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic                  valid;
        logic [C_KEY_W-1:0]    key;
        logic [C_HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic   wr_en;
        t_slot  wr_addr;
        t_entry wr_data;
        t_slot  rd_addr;
    } t_mem_req;

endpackage

/* design/fnvlp_hash.sv */
// Byte-serial FNV-1a hash of a 32-bit key, one byte per clock, low byte first.
module fnvlp_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_key,
    output logic        o_done,
    output logic [31:0] o_hash
);

    logic        r_run;
    logic        r_done;
    logic [1:0]  r_cnt;
    logic [31:0] r_key;
    logic [31:0] r_h;
    logic [31:0] w_mix;
    logic [31:0] w_prod;

    assign w_mix  = r_h ^ {24'd0, r_key[7:0]};
    assign w_prod = w_mix * fnvlp_pkg::C_FNV_PRIME;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 2'd0;
                r_key <= i_key;
                r_h   <= fnvlp_pkg::C_FNV_BASIS;
            end else if (r_run) begin
                r_h   <= w_prod;
                r_key <= {8'd0, r_key[31:8]};
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_hash = r_h;

endmodule

/* design/fnvlp_store.sv */
// Slot memory: valid mark, key and handle per slot, one write and one registered read.
module fnvlp_store (
    input  logic                i_clk,
    input  fnvlp_pkg::t_mem_req i_req,
    output fnvlp_pkg::t_entry   o_rd_data
);

    fnvlp_pkg::t_entry mem [fnvlp_pkg::C_SLOT_COUNT];
    fnvlp_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/fnv_linear_probe_hash_table_core.sv */
// Hash table with FNV-1a hashing and linear probing over a slot memory.
//
// A request (i_action, i_key, i_entry_value) is taken when start is high and
// busy is low. Each request gives exactly one result, shown for one cycle
// with o_strobe high; the receiver cannot hold it off. The next request may
// be taken in the very cycle in which the result is shown.
// The key is hashed one byte per cycle. Probing then reads the slot memory
// once per cycle through its registered read port, and a miss visits every
// slot before it is reported. A full table on insert and the unused action
// code give their result when hashing ends, without probing.
// Reset is synchronous. After it the block sweeps the memory and clears
// every valid mark, one slot a cycle; busy stays high through the sweep and
// the entry count starts at zero.
module fnv_linear_probe_hash_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_key,
    input  logic [31:0] i_entry_value,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_value,
    output logic [12:0] o_slot_index,
    output logic [31:0] o_hash_value
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE
    } t_state;

    t_state                                r_state;
    fnvlp_pkg::t_slot                      r_clr_addr;
    logic [1:0]                            r_action;
    logic [fnvlp_pkg::C_KEY_W-1:0]         r_key;
    logic [fnvlp_pkg::C_HANDLE_W-1:0]      r_handle;
    logic [fnvlp_pkg::C_COUNT_W-1:0]       r_count;
    logic [fnvlp_pkg::C_COUNT_W-1:0]       r_checked;
    fnvlp_pkg::t_slot                      r_next;
    fnvlp_pkg::t_slot                      r_cur;
    logic                                  r_pend;
    logic                                  r_strobe;
    fnvlp_pkg::t_status                    r_status;
    logic [fnvlp_pkg::C_HANDLE_W-1:0]      r_rval;
    fnvlp_pkg::t_slot                      r_slot;

    logic                w_accept;
    logic                w_hash_done;
    logic [31:0]         w_hash;
    logic                w_is_insert;
    logic                w_hit;
    logic                w_last;
    fnvlp_pkg::t_mem_req w_req;
    fnvlp_pkg::t_entry   w_rd;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    fnvlp_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_key   (i_key),
        .o_done  (w_hash_done),
        .o_hash  (w_hash)
    );

    fnvlp_store u_store (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_data (w_rd)
    );

    // Insert looks for a free slot; remove and lookup for a live slot with the key.
    assign w_is_insert = (r_action == fnvlp_pkg::ACT_INSERT);
    assign w_hit  = r_pend && (w_is_insert ? !w_rd.valid
                                           : (w_rd.valid && (w_rd.key == r_key)));
    assign w_last = (r_checked == fnvlp_pkg::C_COUNT_W'(fnvlp_pkg::C_SLOT_COUNT - 1));

    always_comb begin
        w_req         = '0;
        w_req.rd_addr = r_next;
        case (r_state)
            S_CLEAR: begin
                w_req.wr_en   = 1'b1;
                w_req.wr_addr = r_clr_addr;
            end
            S_PROBE: begin
                if (w_hit && (r_action != fnvlp_pkg::ACT_LOOKUP)) begin
                    w_req.wr_en   = 1'b1;
                    w_req.wr_addr = r_cur;
                    if (w_is_insert) begin
                        w_req.wr_data = {1'b1, r_key, r_handle};
                    end else begin
                        w_req.wr_data = {1'b0, w_rd.key, w_rd.handle};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_pend     <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == fnvlp_pkg::C_SLOT_W'(fnvlp_pkg::C_SLOT_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_action <= i_action;
                        r_key    <= i_key;
                        r_handle <= i_entry_value[fnvlp_pkg::C_HANDLE_W-1:0];
                        r_state  <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_pend    <= 1'b0;
                        r_checked <= '0;
                        r_next    <= w_hash[fnvlp_pkg::C_SLOT_W-1:0];
                        r_rval    <= '0;
                        r_slot    <= '0;
                        if (w_is_insert &&
                            (r_count == fnvlp_pkg::C_COUNT_W'(fnvlp_pkg::C_SLOT_COUNT))) begin
                            r_strobe <= 1'b1;
                            r_status <= fnvlp_pkg::ST_FULL;
                            r_state  <= S_IDLE;
                        end else if (w_is_insert || (r_action == fnvlp_pkg::ACT_REMOVE) ||
                                     (r_action == fnvlp_pkg::ACT_LOOKUP)) begin
                            r_state <= S_PROBE;
                        end else begin
                            r_strobe <= 1'b1;
                            r_status <= fnvlp_pkg::ST_NOT_FOUND;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_PROBE: begin
                    // Reads run one slot ahead of the check; nothing is written
                    // until the probe stops, so the early read is harmless.
                    r_next <= r_next + 1'b1;
                    r_cur  <= r_next;
                    r_pend <= 1'b1;
                    if (r_pend) begin
                        if (w_hit) begin
                            r_strobe <= 1'b1;
                            r_status <= fnvlp_pkg::ST_DONE;
                            r_slot   <= r_cur;
                            r_rval   <= w_is_insert ? '0 : w_rd.handle;
                            if (w_is_insert) begin
                                r_count <= r_count + 1'b1;
                            end else if (r_action == fnvlp_pkg::ACT_REMOVE) begin
                                r_count <= r_count - 1'b1;
                            end
                            r_state <= S_IDLE;
                        end else if (w_last) begin
                            r_strobe <= 1'b1;
                            r_status <= fnvlp_pkg::ST_NOT_FOUND;
                            r_state  <= S_IDLE;
                        end else begin
                            r_checked <= r_checked + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_result_value = 32'(r_rval);
    assign o_slot_index   = fnvlp_pkg::C_IDX_W'(r_slot);
    assign o_hash_value   = w_hash;

endmodule

/* design/fnvlp_chk.sv */
// Port-level checker for the hash table core, bound to the top level.
module fnvlp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [1:0]  o_status,
    input logic [31:0] o_result_value,
    input logic [12:0] o_slot_index
);

    // A reset always leads into the clearing sweep.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // A result is only shown once the block is ready for the next transaction.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // After an accepted transaction the block is busy and shows no result in the following cycle.
    a_accept_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe))
        else $error("unexpected state after accepting a transaction");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for two cycles");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == fnvlp_pkg::ST_FULL)) |->
            ((o_result_value == 32'd0) && (o_slot_index == 13'd0)))
        else $error("table-full result carries a handle or slot");

endmodule

bind fnv_linear_probe_hash_table_core fnvlp_chk u_fnvlp_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_status       (o_status),
    .o_result_value (o_result_value),
    .o_slot_index   (o_slot_index)
);

/* tb/fnv_linear_probe_hash_table_checker.sv */
// Key hashing package and the checker that predicts and compares every hash table transaction.
package fnvlp_check_pkg;
    import fnvlp_pkg::*;

    // Action code that the block does not act on; it reports not found.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    function automatic logic [31:0] fnv1a_of_key(input logic [31:0] key);
        logic [31:0] acc;
        acc = C_FNV_BASIS;
        for (int b = 0; b < 4; b++) begin
            acc = (acc ^ {24'd0, key[8*b +: 8]}) * C_FNV_PRIME;
        end
        return acc;
    endfunction
endpackage

module fnv_linear_probe_hash_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_key,
    input  logic [31:0] i_entry_value,
    input  logic        i_strobe,
    input  logic [1:0]  i_status,
    input  logic [31:0] i_result_value,
    input  logic [12:0] i_slot_index,
    input  logic [31:0] i_hash_value,
    output int          o_mismatch_count,
    output int          o_pending_count,
    output int          o_found_count,
    output int          o_missed_count,
    output int          o_full_count
);
    import fnvlp_pkg::*;
    import fnvlp_check_pkg::*;

    typedef struct packed {
        t_status             status;
        logic [31:0]         value;
        logic [C_IDX_W-1:0]  slot;
        logic [31:0]         hash;
    } t_table_outcome;

    bit                    slot_used    [C_SLOT_COUNT];
    logic [31:0]           slot_keys    [C_SLOT_COUNT];
    logic [C_HANDLE_W-1:0] slot_handles [C_SLOT_COUNT];
    int                    stored_count;

    t_table_outcome expected_outcomes [$];
    int mismatches = 0;
    int found      = 0;
    int missed     = 0;
    int full       = 0;

    // Applies one request to the shadow table and returns the result it must give.
    function automatic t_table_outcome predict_table_request(input logic [1:0] act,
            input logic [31:0] key, input logic [31:0] handle);
        t_table_outcome res;
        int pos;
        res.status = ST_NOT_FOUND;
        res.value  = '0;
        res.slot   = '0;
        res.hash   = fnv1a_of_key(key);
        pos = int'(res.hash % C_SLOT_COUNT);
        if (act == ACT_INSERT) begin
            res.status = ST_FULL;
            if (stored_count < C_SLOT_COUNT) begin
                for (int n = 0; n < C_SLOT_COUNT; n++) begin
                    if (!slot_used[pos]) begin
                        slot_used[pos]    = 1'b1;
                        slot_keys[pos]    = key;
                        slot_handles[pos] = handle;
                        stored_count++;
                        res.status = ST_DONE;
                        res.slot   = pos[C_IDX_W-1:0];
                        break;
                    end
                    pos = (pos + 1) % C_SLOT_COUNT;
                end
            end
        end else if (act == ACT_REMOVE || act == ACT_LOOKUP) begin
            // The search runs past empty slots, since removal leaves no marker behind.
            for (int n = 0; n < C_SLOT_COUNT; n++) begin
                if (slot_used[pos] && slot_keys[pos] == key) begin
                    res.status = ST_DONE;
                    res.slot   = pos[C_IDX_W-1:0];
                    res.value  = slot_handles[pos];
                    if (act == ACT_REMOVE) begin
                        slot_used[pos] = 1'b0;
                        if (stored_count > 0) stored_count--;
                    end
                    break;
                end
                pos = (pos + 1) % C_SLOT_COUNT;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_table_outcome want;
        if (!i_rst_n) begin
            slot_used    = '{default: 1'b0};
            stored_count = 0;
            expected_outcomes.delete();
        end else begin
            // Results are checked before the new request is predicted, as a result may
            // appear in the very cycle in which the next transaction is taken.
            if (i_strobe === 1'b1) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result with no request outstanding: status %0d, slot %0d",
                           i_status, i_slot_index);
                    mismatches++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        mismatches++;
                    end
                    if (i_result_value !== want.value) begin
                        $error("result_value: expected %h, actual %h",
                               want.value, i_result_value);
                        mismatches++;
                    end
                    if (i_slot_index !== want.slot) begin
                        $error("slot_index: expected %0d, actual %0d", want.slot, i_slot_index);
                        mismatches++;
                    end
                    if (i_hash_value !== want.hash) begin
                        $error("hash_value: expected %h, actual %h", want.hash, i_hash_value);
                        mismatches++;
                    end
                    case (want.status)
                        ST_DONE:      found++;
                        ST_NOT_FOUND: missed++;
                        default:      full++;
                    endcase
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                expected_outcomes.push_back(predict_table_request(i_action, i_key,
                                                                  i_entry_value));
            end
        end
        o_mismatch_count <= mismatches;
        o_pending_count  <= expected_outcomes.size();
        o_found_count    <= found;
        o_missed_count   <= missed;
        o_full_count     <= full;
    end
endmodule

/* tb/fnv_linear_probe_hash_table_core_tb.sv */
// Stimulus, clock, reset, watchdog and verdict for the FNV-1a linear-probe hash table core.
module fnv_linear_probe_hash_table_core_tb;
    import fnvlp_pkg::*;
    import fnvlp_check_pkg::*;

    localparam int RANDOM_REQUESTS = 1200;
    localparam int MAX_GAP         = 13;
    localparam int WATCHDOG_LIMIT  = 60000;
    localparam int SETTLE_CYCLES   = 16;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic        busy;
    logic [1:0]  i_action      = ACT_INSERT;
    logic [31:0] i_key         = '0;
    logic [31:0] i_entry_value = '0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [31:0] o_result_value;
    logic [12:0] o_slot_index;
    logic [31:0] o_hash_value;

    int mismatch_count;
    int pending_count;
    int found_count;
    int missed_count;
    int full_count;

    int          quiet_cycles = 0;
    int          issued       = 0;
    bit          gaps_on      = 1'b1;
    logic [31:0] live_keys [$];
    logic [31:0] key_at_home [C_SLOT_COUNT];

    always #2 i_clk = ~i_clk;

    fnv_linear_probe_hash_table_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_key          (i_key),
        .i_entry_value  (i_entry_value),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_slot_index   (o_slot_index),
        .o_hash_value   (o_hash_value)
    );

    fnv_linear_probe_hash_table_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_action         (i_action),
        .i_key            (i_key),
        .i_entry_value    (i_entry_value),
        .i_strobe         (o_strobe),
        .i_status         (o_status),
        .i_result_value   (o_result_value),
        .i_slot_index     (o_slot_index),
        .i_hash_value     (o_hash_value),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count),
        .o_found_count    (found_count),
        .o_missed_count   (missed_count),
        .o_full_count     (full_count)
    );

    // Ends the run if neither side completes a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic logic [31:0] random_handle();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [1:0] act, input logic [31:0] key,
                                input logic [31:0] handle);
        int gap;
        // Every so often the sender switches between idling and back-to-back requests.
        if (issued % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_action      <= act;
        i_key         <= key;
        i_entry_value <= handle;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        issued++;
    endtask

    initial begin
        bit          home_taken [C_SLOT_COUNT];
        int          homes_left;
        int          home;
        int          pick;
        int          kind;
        int          idx;
        logic [31:0] cand;
        logic [31:0] probe_key;
        logic [31:0] wrap_key;

        // One key for every home slot, so that keys with a chosen home are at hand.
        home_taken = '{default: 1'b0};
        homes_left = C_SLOT_COUNT;
        cand = $urandom;
        while (homes_left > 0) begin
            home = int'(fnv1a_of_key(cand) % C_SLOT_COUNT);
            if (!home_taken[home]) begin
                home_taken[home]  = 1'b1;
                key_at_home[home] = cand;
                homes_left--;
            end
            cand++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wrap_key = key_at_home[C_SLOT_COUNT-1];
        send_request(ACT_REMOVE, 32'h0, 32'h0);
        send_request(ACT_UNUSED, '1, '1);
        send_request(ACT_INSERT, 32'h0, '1);
        send_request(ACT_INSERT, '1, 32'h0);
        send_request(ACT_LOOKUP, 32'h0, $urandom);
        send_request(ACT_LOOKUP, '1, $urandom);
        // Three copies of a key whose home is the last slot, so probing wraps to the start.
        repeat (3) send_request(ACT_INSERT, wrap_key, $urandom);
        send_request(ACT_LOOKUP, wrap_key, 32'h0);
        send_request(ACT_REMOVE, wrap_key, 32'h0);
        send_request(ACT_LOOKUP, wrap_key, 32'h0);
        send_request(ACT_REMOVE, wrap_key, 32'h0);
        send_request(ACT_REMOVE, wrap_key, 32'h0);
        send_request(ACT_LOOKUP, wrap_key, 32'h0);
        send_request(ACT_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(ACT_LOOKUP, 32'hAAAA_AAAA, 32'hFFFF_0000);
        send_request(ACT_REMOVE, 32'hAAAA_AAAA, 32'h0);
        send_request(ACT_REMOVE, 32'h0, 32'h0);
        send_request(ACT_REMOVE, '1, 32'h0);
        send_request(ACT_UNUSED, 32'h0, 32'h0);

        // Mostly hits on stored keys; misses are kept rare as each one scans the whole table.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (live_keys.size() == 0 && pick >= 32 && pick < 92) pick = 0;
            if (pick < 32) begin
                kind = $urandom_range(0, 9);
                if (kind < 6 || live_keys.size() == 0) begin
                    probe_key = $urandom;
                end else if (kind < 8) begin
                    probe_key = live_keys[$urandom_range(0, live_keys.size() - 1)];
                end else if (kind == 8) begin
                    probe_key = key_at_home[$urandom_range(C_SLOT_COUNT - 12, C_SLOT_COUNT - 1)];
                end else begin
                    probe_key = $urandom_range(0, 1) ? '1 : '0;
                end
                live_keys.push_back(probe_key);
                send_request(ACT_INSERT, probe_key, random_handle());
            end else if (pick < 92) begin
                idx = $urandom_range(0, live_keys.size() - 1);
                probe_key = live_keys[idx];
                if (pick < 70) begin
                    send_request(ACT_LOOKUP, probe_key, random_handle());
                end else begin
                    live_keys.delete(idx);
                    send_request(ACT_REMOVE, probe_key, random_handle());
                end
            end else if (pick < 96) begin
                send_request($urandom_range(0, 1) ? ACT_LOOKUP : ACT_REMOVE, $urandom,
                             random_handle());
            end else begin
                send_request(ACT_UNUSED, $urandom, $urandom);
            end
        end

        while (live_keys.size() > 0) begin
            idx = $urandom_range(0, live_keys.size() - 1);
            probe_key = live_keys[idx];
            live_keys.delete(idx);
            send_request(ACT_REMOVE, probe_key, random_handle());
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: corner cases, %0d random, then removal of every stored key.",
                 issued, RANDOM_REQUESTS);
        $display("Results: %0d done or found, %0d not found, %0d table full; %0d mismatches.",
                 found_count, missed_count, full_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
